// ===== rtl/reversible_deque_macros.svh =====
// Assertion macros shared by the reversible deque checker.
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define RD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reversible_deque check failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define RD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reversible_deque check failed");

`endif

// ===== rtl/rd_pkg.sv =====
// Shared types and constants of the reversible deque.
package rd_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;

    localparam t_word EMPTY_WORD = '1;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REVERSE    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Row-wide control broadcast to every cell
    typedef struct packed {
        logic  shift_up;    // push at physical head: every cell takes its left neighbor
        logic  shift_down;  // pop at physical head: every cell takes its right neighbor
        logic  load_tail;   // push at physical tail: first free cell takes the word
        logic  drop_tail;   // pop at physical tail: last filled cell empties
        t_word value;
    } t_cell_ctl;

endpackage

// ===== rtl/rd_cell.sv =====
// One storage cell of the deque row: a word and its occupancy bit.
module rd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rd_pkg::t_cell_ctl i_ctl,
    input  rd_pkg::t_word     i_left_data,
    input  logic              i_left_occ,
    input  rd_pkg::t_word     i_right_data,
    input  logic              i_right_occ,
    output rd_pkg::t_word     o_data,
    output logic              o_occ,
    output rd_pkg::t_word     o_tail_tap
);
    import rd_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_occ;
    logic  n_occ;
    logic  is_tail;

    // Pick the next content from the neighbors or the broadcast word
    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        if (i_ctl.shift_up) begin
            n_data = i_left_data;
            n_occ  = i_left_occ;
        end else if (i_ctl.shift_down) begin
            n_data = i_right_data;
            n_occ  = i_right_occ;
        end else if (i_ctl.load_tail && !r_occ && i_left_occ) begin
            n_data = i_ctl.value;
            n_occ  = 1'b1;
        end else if (i_ctl.drop_tail && r_occ && !i_right_occ) begin
            n_occ  = 1'b0;
        end
    end

    // Clear occupancy under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Drive the word onto the tail-word tree only from the last filled cell
    assign is_tail    = r_occ && !i_right_occ;
    assign o_data     = r_data;
    assign o_occ      = r_occ;
    assign o_tail_tap = is_tail ? r_data : '0;

endmodule

// ===== rtl/reversible_deque.sv =====
// Top level of the reversible deque: command decode, cell row and result register.
//
// Usage:
//   Input channel: i_valid, o_stall, i_cmd, i_value. An item is taken at a rising
//   edge with i_valid high and o_stall low. Commands: push front, push back,
//   pop front, pop back, toggle reversal; other codes leave the queue as is.
//   Output channel: o_valid, i_stall, o_front_value, o_back_value, o_count,
//   o_status. A result is taken at a rising edge with o_valid high and i_stall low.
//   Result path: the taking edge updates the cell row and marks the item pending;
//   the result register then loads from the row as soon as it is free.
//   Throughput: one item per cycle while the receiver takes results; the row of
//   CAPACITY cells shifts or loads at once for a push or pop, a reversal only flips a flag.
//   Stall: a stalled result holds; one more item may be taken behind it, then
//   o_stall rises until the result register drains.
//   Reset: synchronous, active low; the queue comes up empty and not reversed,
//   with no result pending. Stored words need no clearing.
module reversible_deque (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_cmd,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_front_value,
    output logic signed [31:0]          o_back_value,
    output logic [rd_pkg::CNT_W-1:0]    o_count,
    output logic [1:0]                  o_status
);
    import rd_pkg::*;

    t_cell_ctl cell_ctl;
    t_word     cell_data [CAPACITY];
    logic      cell_occ  [CAPACITY];
    t_word     cell_tap  [CAPACITY];

    logic    accept;
    logic    load_out;
    logic    full;
    logic    empty;
    logic    head_end;
    logic    is_front;
    t_cmd    cmd;
    t_word   tail_word;
    t_word   head_word;

    logic    r_rev;
    logic    n_rev;
    t_count  r_count;
    t_count  n_count;
    logic    r_pend;
    t_status r_pend_status;
    t_status n_status;
    logic    r_out_valid;
    t_word   r_front;
    t_word   r_back;
    t_count  r_out_count;
    t_status r_out_status;

    // Handshake: the result register frees up when it is empty or being taken
    assign load_out = r_pend && (!r_out_valid || !i_stall);
    assign o_stall  = r_pend && !load_out;
    assign accept   = i_valid && !o_stall;

    assign cmd      = t_cmd'(i_cmd);
    assign full     = cell_occ[CAPACITY-1];
    assign empty    = !cell_occ[0];
    assign is_front = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_POP_FRONT);
    assign head_end = (is_front == !r_rev);

    // Decode the command into row control, count, reversal and status
    always_comb begin
        cell_ctl       = '0;
        cell_ctl.value = i_value;
        n_rev          = r_rev;
        n_count        = r_count;
        n_status       = ST_OK;
        if (accept) begin
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        cell_ctl.shift_up  = head_end;
                        cell_ctl.load_tail = !head_end;
                        n_count            = r_count + t_count'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        cell_ctl.shift_down = head_end;
                        cell_ctl.drop_tail  = !head_end;
                        n_count             = r_count - t_count'(1);
                    end
                end
                CMD_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                end
            endcase
        end
    end

    // Row of cells, cell 0 at the physical head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word left_data;
        logic  left_occ;
        t_word right_data;
        logic  right_occ;

        if (g == 0) begin : g_head
            assign left_data = i_value;
            assign left_occ  = 1'b1;
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
            assign left_occ  = cell_occ[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
            assign right_occ  = cell_occ[g+1];
        end

        rd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_left_data  (left_data),
            .i_left_occ   (left_occ),
            .i_right_data (right_data),
            .i_right_occ  (right_occ),
            .o_data       (cell_data[g]),
            .o_occ        (cell_occ[g]),
            .o_tail_tap   (cell_tap[g])
        );
    end

    // Collect the physical tail word from the one-hot taps
    always_comb begin
        tail_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tail_word = tail_word | cell_tap[k];
        end
    end

    assign head_word = cell_data[0];

    // Advance queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev         <= 1'b0;
            r_count       <= '0;
            r_pend        <= 1'b0;
            r_pend_status <= ST_OK;
            r_out_valid   <= 1'b0;
        end else begin
            r_rev   <= n_rev;
            r_count <= n_count;
            if (accept) begin
                r_pend        <= 1'b1;
                r_pend_status <= n_status;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result from the row as it stands after the pending item
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count  <= r_count;
            r_out_status <= r_pend_status;
            if (empty) begin
                r_front <= EMPTY_WORD;
                r_back  <= EMPTY_WORD;
            end else if (r_rev) begin
                r_front <= tail_word;
                r_back  <= head_word;
            end else begin
                r_front <= head_word;
                r_back  <= tail_word;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_count       = r_out_count;
    assign o_status      = r_out_status;

endmodule

// ===== rtl/rd_checker.sv =====
// Port-level checker for the reversible deque and its bind.
`include "reversible_deque_macros.svh"

module rd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [2:0]                  i_cmd,
    input logic signed [31:0]          i_value,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [31:0]          o_front_value,
    input logic signed [31:0]          o_back_value,
    input logic [rd_pkg::CNT_W-1:0]    o_count,
    input logic [1:0]                  o_status
);
    import rd_pkg::*;

    // Count never exceeds the capacity
    `RD_ASSERT_NOW(a_count_bound, o_valid, o_count <= t_count'(CAPACITY))

    // Empty queue reports -1 at both ends
    `RD_ASSERT_NOW(a_empty_ends, o_valid && o_count == '0, o_front_value == EMPTY_WORD && o_back_value == EMPTY_WORD)

    // Overflow only when full, underflow only when empty
    `RD_ASSERT_NOW(a_status_fill, o_valid && (o_status == ST_OVERFLOW || o_status == ST_UNDERFLOW), (o_status == ST_OVERFLOW && o_count == t_count'(CAPACITY)) || (o_status == ST_UNDERFLOW && o_count == '0))

    // Stalled result holds
    `RD_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_front_value) && $stable(o_back_value) && $stable(o_count) && $stable(o_status))

    // Stalled input item holds
    `RD_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_cmd) && $stable(i_value))

endmodule

bind reversible_deque rd_checker u_rd_checker (.*);
